// File: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define SSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ssr_pkg.sv
// shared types and constants for the stream substring replace block
// no dependencies
package ssr_pkg;

  localparam int unsigned REG_W     = 64;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned ADDR_W    = REG_IDX_W + 3;
  localparam int unsigned COUNT_W   = 16;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
  } cfg_t;

endpackage

// File: rtl/ssr_cfg_regs.sv
// apb configuration registers: pattern, replacement and their lengths
// depends on ssr_pkg
module ssr_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssr_pkg::REG_W-1:0]   pwdata,
  output logic [ssr_pkg::REG_W-1:0]   prdata,
  output logic                        pready,
  output ssr_pkg::cfg_t               cfg
);
  import ssr_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_BYTES:      cfg_nxt.pattern_bytes      = pwdata;
        REG_PATTERN_LENGTH:     cfg_nxt.pattern_length     = pwdata[3:0];
        REG_REPLACEMENT_BYTES:  cfg_nxt.replacement_bytes  = pwdata;
        REG_REPLACEMENT_LENGTH: cfg_nxt.replacement_length = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_BYTES:      prdata = cfg_r.pattern_bytes;
      REG_PATTERN_LENGTH:     prdata = {60'd0, cfg_r.pattern_length};
      REG_REPLACEMENT_BYTES:  prdata = cfg_r.replacement_bytes;
      REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg_r.replacement_length};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_t'{pattern_bytes: 64'd0, pattern_length: 4'd1,
                      replacement_bytes: 64'd0, replacement_length: 4'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/ssr_match.sv
// single pass matcher: parallel suffix compares over held bytes plus the new byte
// builds the result burst and the next held state; depends on ssr_pkg
module ssr_match #(
  parameter int PATTERN_MAX     = 8,
  parameter int REPLACEMENT_MAX = 8,
  parameter int HD              = 7,
  parameter int NW              = 4,
  parameter int BURST           = 8,
  parameter int BCW             = 4
) (
  input  ssr_pkg::cfg_t               cfg,
  input  logic                        mode,
  input  logic [7:0]                  data_byte,
  input  logic [7:0]                  held [HD],
  input  logic [NW-1:0]               held_cnt,
  input  logic [ssr_pkg::COUNT_W-1:0] total,
  output logic [7:0]                  held_nxt [HD],
  output logic [NW-1:0]               held_cnt_nxt,
  output logic [ssr_pkg::COUNT_W-1:0] total_nxt,
  output logic [7:0]                  bst_byte [BURST],
  output logic                        bst_valid [BURST],
  output logic [BCW-1:0]              bst_cnt,
  output logic [ssr_pkg::COUNT_W-1:0] bst_count
);
  import ssr_pkg::*;

  localparam logic [3:0] PMAX4 = 4'(PATTERN_MAX);
  localparam logic [3:0] RMAX4 = 4'(REPLACEMENT_MAX);

  logic [3:0]             plen, rlen, n4, sel, len_sel, len_v;
  logic [7:0]             win [PATTERN_MAX];
  logic [7:0]             pat [PATTERN_MAX];
  logic [PATTERN_MAX:0]   cand;
  logic                   match, ok_v;

  always_comb begin
    if (cfg.pattern_length == 4'd0)      plen = 4'd1;
    else if (cfg.pattern_length > PMAX4) plen = PMAX4;
    else                                 plen = cfg.pattern_length;
    if (cfg.replacement_length > RMAX4)  rlen = RMAX4;
    else                                 rlen = cfg.replacement_length;
  end

  assign n4 = 4'(held_cnt) + 4'd1;

  // window: held bytes followed by the new byte
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win[j] = data_byte;
      pat[j] = cfg.pattern_bytes[8*j +: 8];
    end
    for (int j = 0; j < PATTERN_MAX - 1; j++) begin
      if (4'(j) < 4'(held_cnt)) win[j] = held[j];
    end
  end

  // candidate shifts: suffix is a proper pattern prefix, or full match at shift 0
  always_comb begin
    len_v = '0;
    ok_v  = 1'b0;
    for (int s = 0; s <= PATTERN_MAX; s++) begin
      len_v = n4 - 4'(s);
      ok_v  = (4'(s) <= n4) && (len_v <= plen);
      for (int i = 0; i < PATTERN_MAX - s; i++) begin
        if (4'(i) < len_v && win[s+i] != pat[i]) ok_v = 1'b0;
      end
      cand[s] = ok_v && ((len_v < plen) || (s == 0));
    end
  end

  always_comb begin
    sel = n4;
    for (int s = PATTERN_MAX; s >= 0; s--) begin
      if (cand[s]) sel = 4'(s);
    end
  end

  assign len_sel = n4 - sel;
  assign match   = (len_sel == plen);

  always_comb begin
    for (int i = 0; i < HD; i++) held_nxt[i] = held[i];
    held_cnt_nxt = held_cnt;
    total_nxt    = total;
    if (mode == MODE_END) begin
      held_cnt_nxt = '0;
      total_nxt    = '0;
    end else if (match) begin
      held_cnt_nxt = '0;
      if (total != COUNT_MAX) total_nxt = total + 16'd1;
    end else begin
      held_cnt_nxt = NW'(len_sel);
      for (int sh = 0; sh <= PATTERN_MAX; sh++) begin
        if (sel == 4'(sh)) begin
          for (int i = 0; i < HD && i < PATTERN_MAX - sh; i++) held_nxt[i] = win[sh+i];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < BURST; j++) begin
      bst_byte[j]  = 8'd0;
      bst_valid[j] = 1'b0;
    end
    if (mode == MODE_END) begin
      for (int j = 0; j < HD; j++) begin
        if (4'(j) < 4'(held_cnt)) begin
          bst_byte[j]  = held[j];
          bst_valid[j] = 1'b1;
        end
      end
      bst_cnt   = BCW'(held_cnt) + BCW'(1);
      bst_count = total;
    end else if (match) begin
      for (int j = 0; j < BURST; j++) begin
        if (4'(j) < rlen) begin
          bst_byte[j]  = cfg.replacement_bytes[8*j +: 8];
          bst_valid[j] = 1'b1;
        end
      end
      bst_cnt   = (rlen == 4'd0) ? BCW'(1) : BCW'(rlen);
      bst_count = total_nxt;
    end else begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (4'(j) < sel) begin
          bst_byte[j]  = win[j];
          bst_valid[j] = 1'b1;
        end
      end
      bst_cnt   = BCW'(sel);
      bst_count = total_nxt;
    end
  end

endmodule

// File: rtl/ssr_out_buf.sv
// result register: holds one burst and hands it out one beat per cycle while out_stall is low
// depends on ssr_pkg
module ssr_out_buf #(
  parameter int BURST = 8,
  parameter int BCW   = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [7:0]                  ld_byte [BURST],
  input  logic                        ld_valid [BURST],
  input  logic [BCW-1:0]              ld_cnt,
  input  logic [ssr_pkg::COUNT_W-1:0] ld_count,
  output logic                        load_ok,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic [ssr_pkg::COUNT_W-1:0] out_match_count,
  output logic                        out_last
);
  import ssr_pkg::*;

  logic [7:0]         byte_r [BURST];
  logic               vld_r [BURST];
  logic [BCW-1:0]     cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] mc_r;
  logic               out_acc;

  assign out_valid       = (cnt_r != '0);
  assign out_last        = (cnt_r == BCW'(1));
  assign out_byte        = byte_r[0];
  assign out_byte_valid  = vld_r[0];
  assign out_match_count = mc_r;
  assign out_acc         = out_valid & ~out_stall;
  assign load_ok         = (cnt_r == '0) | (out_last & out_acc);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load)         cnt_nxt = ld_cnt;
    else if (out_acc) cnt_nxt = cnt_r - BCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= ld_byte;
      vld_r  <= ld_valid;
      mc_r   <= ld_count;
    end else if (out_acc) begin
      for (int j = 0; j < BURST - 1; j++) begin
        byte_r[j] <= byte_r[j+1];
        vld_r[j]  <= vld_r[j+1];
      end
    end
  end

endmodule

// File: rtl/stream_substring_replace.sv
// top level: streaming find and replace of a configured pattern
// depends on ssr_pkg, ssr_cfg_regs, ssr_match, ssr_out_buf, assert_macros.svh
//
// usage
//   input channel: one beat per source byte (in_mode 0) or an end beat (in_mode 1).
//   output channel: text bytes (out_byte_valid 1) and markers (out_byte_valid 0);
//   out_last marks the final beat caused by one input beat, out_match_count the
//   replacements so far in the current string.
//   a data byte gives 0 to 8 beats: released bytes, or the replacement on a match
//   (one marker beat for an empty replacement). an end beat gives the held bytes
//   and one closing marker with out_last, then the string state clears.
//   path: a beat taken into the input register is matched from there, and its
//   result burst is loaded into the result register, from which it is offered.
//   throughput: one input beat per cycle while each beat gives at most one result
//   and out_stall is low; a beat with several results holds the result register
//   until the one output port has taken them all. the input register keeps taking
//   one beat while a burst drains. when out_stall is high the current result holds;
//   in_stall rises when the input register is full and the result register busy.
//   reset (rst_n low, synchronous) empties both registers, drops held bytes and
//   the count, and sets pattern length 1, other registers 0. configuration must be
//   written over the apb port while the block is idle; the block does not enforce it.
module stream_substring_replace #(
  parameter int PATTERN_MAX     = 8,
  parameter int REPLACEMENT_MAX = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic [ssr_pkg::COUNT_W-1:0] out_match_count,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssr_pkg::REG_W-1:0]   pwdata,
  output logic [ssr_pkg::REG_W-1:0]   prdata,
  output logic                        pready
);
  import ssr_pkg::*;
  `include "assert_macros.svh"

  localparam int HD    = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int NW    = $clog2(PATTERN_MAX + 1);
  localparam int BURST = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX : REPLACEMENT_MAX;
  localparam int BCW   = $clog2(BURST + 1);

  cfg_t               cfg;
  logic               in_valid_r, in_valid_nxt;
  logic               mode_r;
  logic [7:0]         byte_r;
  logic               in_acc, adv, load_ok;
  logic [7:0]         held_r [HD];
  logic [7:0]         held_nxt [HD];
  logic [NW-1:0]      held_cnt_r, held_cnt_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [7:0]         bst_byte [BURST];
  logic               bst_valid [BURST];
  logic [BCW-1:0]     bst_cnt;
  logic [COUNT_W-1:0] bst_count;

  ssr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  assign in_stall = in_valid_r & ~load_ok;
  assign in_acc   = in_valid & ~in_stall;
  assign adv      = in_valid_r & load_ok;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc)   in_valid_nxt = 1'b1;
    else if (adv) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else        in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      byte_r <= in_data_byte;
    end
  end

  ssr_match #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX),
    .HD              (HD),
    .NW              (NW),
    .BURST           (BURST),
    .BCW             (BCW)
  ) u_match (
    .cfg          (cfg),
    .mode         (mode_r),
    .data_byte    (byte_r),
    .held         (held_r),
    .held_cnt     (held_cnt_r),
    .total        (total_r),
    .held_nxt     (held_nxt),
    .held_cnt_nxt (held_cnt_nxt),
    .total_nxt    (total_nxt),
    .bst_byte     (bst_byte),
    .bst_valid    (bst_valid),
    .bst_cnt      (bst_cnt),
    .bst_count    (bst_count)
  );

  // string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      total_r    <= '0;
    end else if (adv) begin
      held_cnt_r <= held_cnt_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) held_r <= held_nxt;
  end

  ssr_out_buf #(
    .BURST (BURST),
    .BCW   (BCW)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (adv),
    .ld_byte         (bst_byte),
    .ld_valid        (bst_valid),
    .ld_cnt          (bst_cnt),
    .ld_count        (bst_count),
    .load_ok         (load_ok),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_match_count (out_match_count),
    .out_last        (out_last)
  );

  `SSR_ASSERT_IMPL(a_held_bound, 1'b1, held_cnt_r < NW'(PATTERN_MAX), "held count too large")
  `SSR_ASSERT_NEXT(a_end_clears, adv && mode_r == MODE_END,
                   held_cnt_r == '0 && total_r == '0, "end beat left string state")
  `SSR_ASSERT_NEXT(a_end_result, adv && mode_r == MODE_END, out_valid,
                   "end beat gave no closing result")
  `SSR_ASSERT_IMPL(a_stall_full, in_stall, in_valid_r, "stall with empty input register")

endmodule
